@@ rtl/core/btri_pkg.sv @@
// shared types, register indexes and index helpers for the box/triangle overlap test
package btri_pkg;

    typedef logic [2:0] btri_reg_idx_t;

    localparam btri_reg_idx_t REG_BOX_MIN_X = 3'd0;
    localparam btri_reg_idx_t REG_BOX_MIN_Y = 3'd1;
    localparam btri_reg_idx_t REG_BOX_MIN_Z = 3'd2;
    localparam btri_reg_idx_t REG_BOX_MAX_X = 3'd3;
    localparam btri_reg_idx_t REG_BOX_MAX_Y = 3'd4;
    localparam btri_reg_idx_t REG_BOX_MAX_Z = 3'd5;
    localparam btri_reg_idx_t REG_TOLERANCE = 3'd6;

    typedef struct packed {
        logic valid;
        logic edge_ok;
        logic face_ok;
    } btri_flags_t;

    // next index around a triangle or around the three axes
    function automatic int nxt3(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

endpackage

@@ rtl/core/box_triangle_overlap_test.sv @@
// top level of the box/triangle separating-axis overlap test
//
//   channel  | handshake               | word
//   ---------+-------------------------+-----------------------------------------
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data (box corners, tolerance)
//   triangle | start, accepted !busy   | first_*, second_*, third_* vertices
//   result   | done, one-cycle strobe  | overlaps
//
// an eight-stage pipeline, set by the split normal-axis products and their wide sums
// one triangle accepted every cycle, results leave in the order of acceptance
// busy is always low and cfg_ready always high; the result side cannot stall
// reset clears the valid bits and loads the unit box with tolerance one
module box_triangle_overlap_test
    import btri_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  btri_reg_idx_t                 cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    input  logic signed [COORD_WIDTH-1:0] third_x,
    input  logic signed [COORD_WIDTH-1:0] third_y,
    input  logic signed [COORD_WIDTH-1:0] third_z,
    output logic                          done,
    output logic                          overlaps
);

    localparam logic [COORD_WIDTH-1:0] MAX_RESET = COORD_WIDTH'(65536);

    logic signed [COORD_WIDTH-1:0] box_min_reg [3];
    logic signed [COORD_WIDTH-1:0] box_max_reg [3];
    logic        [15:0]            tol_reg;
    logic signed [COORD_WIDTH:0]   c2 [3];
    logic signed [COORD_WIDTH:0]   e2 [3];
    logic signed [COORD_WIDTH-1:0] t [3][3];
    logic                          accept;

    logic                          s1_valid;
    logic signed [COORD_WIDTH+1:0] s1_v [3][3];
    logic signed [COORD_WIDTH:0]   s1_f [3][3];
    logic signed [COORD_WIDTH+1:0] s1_absf [3][3];

    btri_flags_t                     s4_flags;
    logic signed [2*COORD_WIDTH+3:0] s4_n [3];
    logic signed [2*COORD_WIDTH+3:0] s4_absn [3];
    logic signed [COORD_WIDTH+1:0]   s4_v0 [3];

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                box_min_reg[c] <= '0;
                box_max_reg[c] <= MAX_RESET;
            end
            tol_reg <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                REG_TOLERANCE: tol_reg        <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // doubled centre and extent keep the half-values exact
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            c2[c] = (COORD_WIDTH+1)'(box_min_reg[c]) + (COORD_WIDTH+1)'(box_max_reg[c]);
            e2[c] = (COORD_WIDTH+1)'(box_max_reg[c]) - (COORD_WIDTH+1)'(box_min_reg[c]);
        end
    end

    assign t[0][0] = first_x;
    assign t[0][1] = first_y;
    assign t[0][2] = first_z;
    assign t[1][0] = second_x;
    assign t[1][1] = second_y;
    assign t[1][2] = second_z;
    assign t[2][0] = third_x;
    assign t[2][1] = third_y;
    assign t[2][2] = third_z;

    btri_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .t         (t),
        .c2        (c2),
        .out_valid (s1_valid),
        .v         (s1_v),
        .f         (s1_f),
        .absf      (s1_absf)
    );

    btri_axes #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_axes (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .v        (s1_v),
        .f        (s1_f),
        .absf     (s1_absf),
        .e2       (e2),
        .tol      (tol_reg),
        .flags    (s4_flags),
        .n        (s4_n),
        .absn     (s4_absn),
        .v0       (s4_v0)
    );

    btri_norm #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (s4_flags),
        .n        (s4_n),
        .absn     (s4_absn),
        .v0       (s4_v0),
        .e2       (e2),
        .tol      (tol_reg),
        .done     (done),
        .overlaps (overlaps)
    );

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 done)
        else $error("accepted word produced no result after eight cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 8))
        else $error("result strobe without a matching accepted word");

    a_flag_qualified: assert property (@(posedge clk) disable iff (!rst_n)
        overlaps |-> done)
        else $error("overlap flag raised outside a result cycle");

    a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s4_flags.valid |-> $past(accept, 4))
        else $error("mid-pipeline valid bit out of step with acceptance");
`endif

endmodule

@@ rtl/core/btri_prep.sv @@
// first stage: doubled box-relative vertices, edge vectors and their magnitudes
module btri_prep
    import btri_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] t [3][3],
    input  logic signed [COORD_WIDTH:0]   c2 [3],
    output logic                          out_valid,
    output logic signed [COORD_WIDTH+1:0] v [3][3],
    output logic signed [COORD_WIDTH:0]   f [3][3],
    output logic signed [COORD_WIDTH+1:0] absf [3][3]
);

    localparam int VW = COORD_WIDTH + 2;
    localparam int FW = COORD_WIDTH + 1;

    logic                 valid_reg;
    logic signed [VW-1:0] v_next [3][3];
    logic signed [VW-1:0] v_reg [3][3];
    logic signed [FW-1:0] f_next [3][3];
    logic signed [FW-1:0] f_reg [3][3];
    logic signed [VW-1:0] absf_next [3][3];
    logic signed [VW-1:0] absf_reg [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                v_next[k][c] = (VW'(t[k][c]) <<< 1) - VW'(c2[c]);
                f_next[k][c] = FW'(t[nxt3(k)][c]) - FW'(t[k][c]);
                absf_next[k][c] = f_next[k][c][FW-1] ? -VW'(f_next[k][c]) : VW'(f_next[k][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        f_reg    <= f_next;
        absf_reg <= absf_next;
    end

    assign out_valid = valid_reg;
    assign v         = v_reg;
    assign f         = f_reg;
    assign absf      = absf_reg;

endmodule

@@ rtl/core/btri_axes.sv @@
// edge-axis and face-axis tests, triangle normal and its magnitude (stages two to four)
module btri_axes
    import btri_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [COORD_WIDTH+1:0]   v [3][3],
    input  logic signed [COORD_WIDTH:0]     f [3][3],
    input  logic signed [COORD_WIDTH+1:0]   absf [3][3],
    input  logic signed [COORD_WIDTH:0]     e2 [3],
    input  logic        [15:0]              tol,
    output btri_flags_t                     flags,
    output logic signed [2*COORD_WIDTH+3:0] n [3],
    output logic signed [2*COORD_WIDTH+3:0] absn [3],
    output logic signed [COORD_WIDTH+1:0]   v0 [3]
);

    localparam int VW  = COORD_WIDTH + 2;
    localparam int MW  = 2 * COORD_WIDTH + 3;
    localparam int PW  = 2 * COORD_WIDTH + 4;
    localparam int NW  = 2 * COORD_WIDTH + 4;
    localparam int FCW = COORD_WIDTH + 3;
    localparam int EXW = (PW + 2 > FRAC_BITS + 20) ? PW + 2 : FRAC_BITS + 20;

    // stage two: products
    logic                 valid2_reg;
    logic signed [MW-1:0] pa_next [3][3][3];
    logic signed [MW-1:0] pb_next [3][3][3];
    logic signed [MW-1:0] pa_reg [3][3][3];
    logic signed [MW-1:0] pb_reg [3][3][3];
    logic signed [MW-1:0] ra_next [3][3];
    logic signed [MW-1:0] rb_next [3][3];
    logic signed [MW-1:0] ra_reg [3][3];
    logic signed [MW-1:0] rb_reg [3][3];
    logic signed [MW-1:0] na_next [3];
    logic signed [MW-1:0] nb_next [3];
    logic signed [MW-1:0] na_reg [3];
    logic signed [MW-1:0] nb_reg [3];
    logic                 face_ok_next;
    logic                 face_ok2_reg;
    logic signed [VW-1:0] v0_2_reg [3];

    // stage three: differences and sums
    logic                 valid3_reg;
    logic signed [PW-1:0] p_next [3][3][3];
    logic signed [PW-1:0] p_reg [3][3][3];
    logic signed [PW-1:0] r_next [3][3];
    logic signed [PW-1:0] r_reg [3][3];
    logic signed [NW-1:0] n_next [3];
    logic signed [NW-1:0] n3_reg [3];
    logic                 face_ok3_reg;
    logic signed [VW-1:0] v0_3_reg [3];

    // stage four: compares
    btri_flags_t          flags_reg;
    logic                 edge_ok_next;
    logic signed [NW-1:0] absn_next [3];
    logic signed [NW-1:0] n4_reg [3];
    logic signed [NW-1:0] absn_reg [3];
    logic signed [VW-1:0] v0_4_reg [3];

    logic signed [FCW-1:0] tol_face;
    logic signed [EXW-1:0] eps2;

    assign tol_face = $signed(FCW'({tol, 1'b0}));
    assign eps2     = $signed(EXW'({tol, 1'b0}) << FRAC_BITS);

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa_next[e][i][k] = v[k][nxt3(nxt3(i))] * f[e][nxt3(i)];
                    pb_next[e][i][k] = v[k][nxt3(i)] * f[e][nxt3(nxt3(i))];
                end
                ra_next[e][i] = e2[nxt3(i)] * absf[e][nxt3(nxt3(i))];
                rb_next[e][i] = e2[nxt3(nxt3(i))] * absf[e][nxt3(i)];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            na_next[c] = f[0][nxt3(c)] * f[1][nxt3(nxt3(c))];
            nb_next[c] = f[0][nxt3(nxt3(c))] * f[1][nxt3(c)];
        end
    end

    // box face axes
    always_comb
    begin
        logic signed [FCW-1:0] mx;
        logic signed [FCW-1:0] mn;
        logic signed [FCW-1:0] bound;
        face_ok_next = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            mx = FCW'(v[0][c]);
            mn = FCW'(v[0][c]);
            for (int k = 1; k < 3; k++)
            begin
                if (FCW'(v[k][c]) > mx)
                begin
                    mx = FCW'(v[k][c]);
                end
                if (FCW'(v[k][c]) < mn)
                begin
                    mn = FCW'(v[k][c]);
                end
            end
            bound = FCW'(e2[c]) + tol_face;
            if ((mx < -bound) || (mn > bound))
            begin
                face_ok_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p_next[e][i][k] = PW'(pa_reg[e][i][k]) - PW'(pb_reg[e][i][k]);
                end
                r_next[e][i] = PW'(ra_reg[e][i]) + PW'(rb_reg[e][i]);
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            n_next[c] = NW'(na_reg[c]) - NW'(nb_reg[c]);
        end
    end

    // edge axes: reject when max(-max p, min p) > r + tolerance
    always_comb
    begin
        logic signed [EXW-1:0] mx;
        logic signed [EXW-1:0] mn;
        logic signed [EXW-1:0] lhs;
        logic signed [EXW-1:0] rhs;
        edge_ok_next = 1'b1;
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mx = EXW'(p_reg[e][i][0]);
                mn = EXW'(p_reg[e][i][0]);
                for (int k = 1; k < 3; k++)
                begin
                    if (EXW'(p_reg[e][i][k]) > mx)
                    begin
                        mx = EXW'(p_reg[e][i][k]);
                    end
                    if (EXW'(p_reg[e][i][k]) < mn)
                    begin
                        mn = EXW'(p_reg[e][i][k]);
                    end
                end
                lhs = (-mx > mn) ? -mx : mn;
                rhs = EXW'(r_reg[e][i]) + eps2;
                if (lhs > rhs)
                begin
                    edge_ok_next = 1'b0;
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            absn_next[c] = n3_reg[c][NW-1] ? -n3_reg[c] : n3_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            valid2_reg        <= in_valid;
            valid3_reg        <= valid2_reg;
            flags_reg.valid   <= valid3_reg;
            flags_reg.edge_ok <= edge_ok_next;
            flags_reg.face_ok <= face_ok3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        face_ok2_reg <= face_ok_next;
        v0_2_reg     <= v[0];
        p_reg        <= p_next;
        r_reg        <= r_next;
        n3_reg       <= n_next;
        face_ok3_reg <= face_ok2_reg;
        v0_3_reg     <= v0_2_reg;
        n4_reg       <= n3_reg;
        absn_reg     <= absn_next;
        v0_4_reg     <= v0_3_reg;
    end

    assign flags = flags_reg;
    assign n     = n4_reg;
    assign absn  = absn_reg;
    assign v0    = v0_4_reg;

endmodule

@@ rtl/core/btri_norm.sv @@
// triangle normal axis: split wide products, sums and the final compare (stages five to eight)
module btri_norm
    import btri_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  btri_flags_t                     flags,
    input  logic signed [2*COORD_WIDTH+3:0] n [3],
    input  logic signed [2*COORD_WIDTH+3:0] absn [3],
    input  logic signed [COORD_WIDTH+1:0]   v0 [3],
    input  logic signed [COORD_WIDTH:0]     e2 [3],
    input  logic        [15:0]              tol,
    output logic                            done,
    output logic                            overlaps
);

    localparam int NW  = 2 * COORD_WIDTH + 4;
    localparam int LB  = COORD_WIDTH + 1;
    localparam int PHW = 2 * COORD_WIDTH + 6;
    localparam int DW  = (3 * COORD_WIDTH + 9 > 2 * FRAC_BITS + 20) ?
                         3 * COORD_WIDTH + 9 : 2 * FRAC_BITS + 20;

    btri_flags_t           f5_reg;
    btri_flags_t           f6_reg;
    btri_flags_t           f7_reg;
    logic signed [PHW-1:0] plo_next [3];
    logic signed [PHW-1:0] phi_next [3];
    logic signed [PHW-1:0] rlo_next [3];
    logic signed [PHW-1:0] rhi_next [3];
    logic signed [PHW-1:0] plo_reg [3];
    logic signed [PHW-1:0] phi_reg [3];
    logic signed [PHW-1:0] rlo_reg [3];
    logic signed [PHW-1:0] rhi_reg [3];
    logic signed [DW-1:0]  dc_next [3];
    logic signed [DW-1:0]  rc_next [3];
    logic signed [DW-1:0]  dc_reg [3];
    logic signed [DW-1:0]  rc_reg [3];
    logic signed [DW-1:0]  dist_next;
    logic signed [DW-1:0]  rr_next;
    logic signed [DW-1:0]  dist_reg;
    logic signed [DW-1:0]  rr_reg;
    logic signed [DW-1:0]  absd;
    logic signed [DW-1:0]  eps3;
    logic                  done_reg;
    logic                  overlaps_reg;

    assign eps3 = $signed(DW'({tol, 1'b0}) << (2 * FRAC_BITS));

    // each wide operand is split into an unsigned low part and a signed high part
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            plo_next[c] = $signed({1'b0, n[c][LB-1:0]}) * v0[c];
            phi_next[c] = $signed(n[c][NW-1:LB]) * v0[c];
            rlo_next[c] = $signed({1'b0, absn[c][LB-1:0]}) * e2[c];
            rhi_next[c] = $signed(absn[c][NW-1:LB]) * e2[c];
            dc_next[c]  = (DW'(phi_reg[c]) <<< LB) + DW'(plo_reg[c]);
            rc_next[c]  = (DW'(rhi_reg[c]) <<< LB) + DW'(rlo_reg[c]);
        end
        dist_next = dc_reg[0] + dc_reg[1] + dc_reg[2];
        rr_next   = rc_reg[0] + rc_reg[1] + rc_reg[2] + eps3;
        absd      = dist_reg[DW-1] ? -dist_reg : dist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f5_reg       <= '0;
            f6_reg       <= '0;
            f7_reg       <= '0;
            done_reg     <= 1'b0;
            overlaps_reg <= 1'b0;
        end
        else
        begin
            f5_reg       <= flags;
            f6_reg       <= f5_reg;
            f7_reg       <= f6_reg;
            done_reg     <= f7_reg.valid;
            overlaps_reg <= f7_reg.valid & f7_reg.edge_ok & f7_reg.face_ok & (absd <= rr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        rlo_reg  <= rlo_next;
        rhi_reg  <= rhi_next;
        dc_reg   <= dc_next;
        rc_reg   <= rc_next;
        dist_reg <= dist_next;
        rr_reg   <= rr_next;
    end

    assign done     = done_reg;
    assign overlaps = overlaps_reg;

endmodule

@@ sim/tb_box_triangle_overlap_test.sv @@
// self-checking testbench for the box/triangle separating-axis overlap test
module tb_box_triangle_overlap_test;
    import btri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam btri_reg_idx_t REG_UNUSED = 3'd7;
    localparam int LATENCY = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 130;

    typedef logic [8:0][31:0] tri_t;
    typedef logic signed [159:0] wv_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    btri_reg_idx_t cfg_index;
    logic [31:0] cfg_data;
    logic start;
    logic busy;
    logic signed [31:0] first_x, first_y, first_z;
    logic signed [31:0] second_x, second_y, second_z;
    logic signed [31:0] third_x, third_y, third_z;
    logic done;
    logic overlaps;

    box_triangle_overlap_test uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .done(done), .overlaps(overlaps)
    );

    // box mirror
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic [15:0] box_tol;

    tri_t pending_tris[$];
    logic expected_hits[$];
    int errors = 0;
    int tris_sent = 0;
    int hits_seen = 0;
    int misses_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    logic word_taken = 1'b0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic add_tri(input tri_t t);
        pending_tris = {pending_tris, t};
    endtask

    function automatic wv_t wabs(input wv_t a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic wv_t wmax3(input wv_t a, input wv_t b, input wv_t c);
        wv_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic wv_t wmin3(input wv_t a, input wv_t b, input wv_t c);
        wv_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic predict_overlap(input tri_t t);
        wv_t c2 [3];
        wv_t e2 [3];
        wv_t v [3][3];
        wv_t f [3][3];
        wv_t p [3];
        wv_t pt [3][3];
        wv_t nrm [3];
        wv_t tol2, r, d, mx, mn, bnd, sep;
        logic hit;
        int j, m;
        hit = 1'b1;
        tol2 = '0;
        tol2[16:0] = {box_tol, 1'b0};
        for (int c = 0; c < 3; c++)
        begin
            c2[c] = wv_t'(box_lo[c]) + wv_t'(box_hi[c]);
            e2[c] = wv_t'(box_hi[c]) - wv_t'(box_lo[c]);
        end
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++)
            begin
                pt[k][c] = wv_t'($signed(t[k*3+c]));
                v[k][c] = 2 * pt[k][c] - c2[c];
            end
        for (int e = 0; e < 3; e++)
            for (int c = 0; c < 3; c++)
                f[e][c] = pt[(e+1)%3][c] - pt[e][c];
        // edge cross axes
        for (int e = 0; e < 3; e++)
            for (int i = 0; i < 3; i++)
            begin
                j = (i + 1) % 3;
                m = (i + 2) % 3;
                for (int k = 0; k < 3; k++)
                    p[k] = v[k][m] * f[e][j] - v[k][j] * f[e][m];
                r = e2[j] * wabs(f[e][m]) + e2[m] * wabs(f[e][j]);
                mx = wmax3(p[0], p[1], p[2]);
                mn = wmin3(p[0], p[1], p[2]);
                sep = (-mx > mn) ? -mx : mn;
                if (sep > r + (tol2 <<< 16))
                    hit = 1'b0;
            end
        // face axes
        for (int c = 0; c < 3; c++)
        begin
            mx = wmax3(v[0][c], v[1][c], v[2][c]);
            mn = wmin3(v[0][c], v[1][c], v[2][c]);
            bnd = e2[c] + tol2;
            if (mx < -bnd || mn > bnd)
                hit = 1'b0;
        end
        nrm[0] = f[0][1] * f[1][2] - f[0][2] * f[1][1];
        nrm[1] = f[0][2] * f[1][0] - f[0][0] * f[1][2];
        nrm[2] = f[0][0] * f[1][1] - f[0][1] * f[1][0];
        d = wabs(nrm[0] * v[0][0] + nrm[1] * v[0][1] + nrm[2] * v[0][2]);
        r = e2[0] * wabs(nrm[0]) + e2[1] * wabs(nrm[1]) + e2[2] * wabs(nrm[2]);
        if (d > r + (tol2 <<< 32))
            hit = 1'b0;
        return hit;
    endfunction

    function automatic tri_t mk_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_t t;
        t[0] = ax; t[1] = ay; t[2] = az;
        t[3] = bx; t[4] = by; t[5] = bz;
        t[6] = cx; t[7] = cy; t[8] = cz;
        return t;
    endfunction

    function automatic logic [31:0] near_coord(input int c);
        longint w, lo;
        lo = longint'(box_lo[c]);
        w = longint'(box_hi[c]) - lo;
        if (w < 0)
            w = -w;
        w = w + 4;
        return 32'(lo - w / 2 + longint'({32'b0, $urandom}) % (2 * w));
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int kind;
        int anchor;
        kind = $urandom_range(0, 9);
        anchor = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 5)
                t[i] = near_coord(i % 3);
            else if (kind < 7)
                // small triangle hugging one vertex, probes faces and edges closely
                t[i] = (i / 3 == anchor) ? near_coord(i % 3)
                                         : 32'(near_coord(i % 3));
            else if (kind < 9)
                t[i] = $urandom;
            else
                t[i] = edge_value();
        end
        if (kind >= 5 && kind < 7)
            for (int i = 0; i < 9; i++)
                if (i / 3 != anchor)
                    t[i] = t[anchor*3 + i%3] + 32'($signed($urandom_range(0, 64)) - 32);
        return t;
    endfunction

    task automatic write_reg(input btri_reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_BOX_MIN_X: box_lo[0] = val;
            REG_BOX_MIN_Y: box_lo[1] = val;
            REG_BOX_MIN_Z: box_lo[2] = val;
            REG_BOX_MAX_X: box_hi[0] = val;
            REG_BOX_MAX_Y: box_hi[1] = val;
            REG_BOX_MAX_Z: box_hi[2] = val;
            REG_TOLERANCE: box_tol = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_box(input int lx, ly, lz, hx, hy, hz, input logic [31:0] tol);
        write_reg(REG_BOX_MIN_X, lx);
        write_reg(REG_BOX_MIN_Y, ly);
        write_reg(REG_BOX_MIN_Z, lz);
        write_reg(REG_BOX_MAX_X, hx);
        write_reg(REG_BOX_MAX_Y, hy);
        write_reg(REG_BOX_MAX_Z, hz);
        write_reg(REG_TOLERANCE, tol);
    endtask

    task automatic drain();
        while (pending_tris.size() != 0 || start || expected_hits.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        repeat (count)
            add_tri(random_tri());
        drain();
    endtask

    // triangle word driver
    always @(negedge clk)
    begin
        logic next_start;
        next_start = start;
        if (word_taken)
        begin
            word_taken = 1'b0;
            void'(pending_tris.pop_front());
            next_start = 1'b0;
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
        if (!next_start && rst_n)
        begin
            if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (pending_tris.size() != 0)
            begin
                {third_z, third_y, third_x, second_z, second_y, second_x,
                 first_z, first_y, first_x} <= pending_tris[0];
                next_start = 1'b1;
            end
        end
        start <= next_start;
    end

    // acceptance and result checking
    always @(posedge clk)
    begin
        logic want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: result with nothing expected, overlaps=%0b", $realtime, overlaps);
                errors = errors + 1;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (overlaps !== want)
                begin
                    $display("%0t: overlaps mismatch expected %0b actual %0b",
                             $realtime, want, overlaps);
                    errors = errors + 1;
                end
                if (want)
                    hits_seen = hits_seen + 1;
                else
                    misses_seen = misses_seen + 1;
            end
        end
        if (rst_n && start && !busy)
        begin
            expected_hits = {expected_hits, predict_overlap({third_z, third_y, third_x,
                second_z, second_y, second_x, first_z, first_y, first_x})};
            tris_sent = tris_sent + 1;
            word_taken = 1'b1;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("box_triangle_overlap_test test failed");
            $finish;
        end
    end

    initial
    begin
        int lx, ly, lz;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BOX_MIN_X;
        cfg_data = '0;
        start = 1'b0;
        {first_x, first_y, first_z, second_x, second_y, second_z,
         third_x, third_y, third_z} = '0;
        box_lo = '{0, 0, 0};
        box_hi = '{65536, 65536, 65536};
        box_tol = 16'd1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed cases against the reset unit box
        add_tri(mk_tri(16384, 16384, 16384, 32768, 16384, 16384,
                       16384, 32768, 32768));
        add_tri(mk_tri(300000, 0, 0, 400000, 0, 0, 300000, 90000, 0));
        // vertex exactly on the face plus tolerance, then one unit beyond
        add_tri(mk_tri(65537, 0, 0, 70000, 0, 0, 70000, 100, 0));
        add_tri(mk_tri(65538, 0, 0, 70000, 0, 0, 70000, 100, 0));
        add_tri(mk_tri(-1, 5, 5, -9, 5, 5, -9, 9, 5));
        add_tri(mk_tri(-2, 5, 5, -9, 5, 5, -9, 9, 5));
        // degenerate: all three vertices equal, and collinear
        add_tri(mk_tri(100, 100, 100, 100, 100, 100, 100, 100, 100));
        add_tri(mk_tri(-9999, -9999, -9999, 0, 0, 0, 99999, 99999, 99999));
        // large plane passing near the box corner
        add_tri(mk_tri(-1000000, 200000, 0, 200000, -1000000, 0,
                       200000, 200000, 131075));
        add_tri(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        add_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h80000000,
                       32'h80000000, 32'h7fffffff, 32'h7fffffff));
        add_tri(mk_tri(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 0, 0, 32'h7fffffff, 32'h80000000));
        drain();
        random_phase(RAND_PER_PHASE);

        // index with no register behind it must change nothing
        write_reg(REG_UNUSED, 32'hdead_beef);
        random_phase(20);

        // full-range box with the widest tolerance
        set_box(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffff_ffff);
        add_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h7fffffff, 32'h80000000));
        random_phase(RAND_PER_PHASE);

        // zero tolerance, small offset box
        set_box(-70000, 12345, -5, 90000, 80000, 300000, 32'h0);
        add_tri(mk_tri(90000, 12345, -5, 90001, 12345, -5, 90001, 12346, -5));
        add_tri(mk_tri(90001, 12345, -5, 90002, 12345, -5, 90001, 12346, -5));
        random_phase(RAND_PER_PHASE);

        // inverted box: minimum above maximum on every axis
        set_box(200000, 150000, 99999, -100000, -50000, -1, 32'd300);
        random_phase(RAND_PER_PHASE);

        // thin flat box
        set_box(-65536, -65536, 7, 65536, 65536, 7, 32'd2);
        random_phase(RAND_PER_PHASE);

        repeat (3)
        begin
            lx = $signed($urandom_range(0, 2000000)) - 1000000;
            ly = $signed($urandom_range(0, 2000000)) - 1000000;
            lz = $signed($urandom_range(0, 2000000)) - 1000000;
            set_box(lx, ly, lz, lx + $urandom_range(0, 400000), ly + $urandom_range(0, 400000),
                    lz + $urandom_range(0, 400000), $urandom);
            random_phase(RAND_PER_PHASE);
        end

        $display("covered %0d triangles over 8 box settings: %0d touching, %0d separated",
                 tris_sent, hits_seen, misses_seen);
        $display("settings included inverted, flat, full-range, zero and max tolerance boxes");
        if (errors == 0)
            $display("box_triangle_overlap_test test passed");
        else
            $display("box_triangle_overlap_test test failed");
        $finish;
    end

endmodule
